// ===== hdl/semiprime_range_test_defines.svh =====
// ----------------------------------------------------------------------------
// semiprime_range_test_defines
// Assertion macros for the checker file of the semiprime range tester.
// ----------------------------------------------------------------------------
`ifndef SEMIPRIME_RANGE_TEST_DEFINES_SVH
`define SEMIPRIME_RANGE_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("semiprime_range_test check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("semiprime_range_test check failed");

`endif

// ===== hdl/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg
// Widths, datapath operations, jump conditions and the control program of
// the semiprime range tester.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int FIELD_W     = 16;
  localparam int SQ_W        = 2 * VALUE_WIDTH;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int PROG_LEN    = 18;
  localparam int PC_W        = $clog2(PROG_LEN);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [SQ_W-1:0]        square_t;
  typedef logic [FIELD_W-1:0]     field_t;
  typedef logic [PC_W-1:0]        pc_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NONE,
    OP_D_INIT,
    OP_SQUARE,
    OP_DIV_START,
    OP_D_INC,
    OP_FOUND,
    OP_SEMI,
    OP_EMIT
  } srt_op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_SMALL,
    C_SQ_GT,
    C_DIV_BUSY,
    C_REM_ZERO,
    C_OUT_FULL
  } srt_cond_t;

  typedef struct packed {
    srt_op_t   op;
    srt_cond_t cond;
    pc_t       target;
  } srt_cw_t;

  typedef struct packed {
    logic in_fire;
    logic tiny;
    logic sq_gt;
    logic div_busy;
    logic rem_zero;
    logic out_full;
  } srt_flags_t;

  localparam pc_t S_IDLE  = PC_W'(0);
  localparam pc_t S_SQ1   = PC_W'(3);
  localparam pc_t S_WAIT1 = PC_W'(6);
  localparam pc_t S_FOUND = PC_W'(9);
  localparam pc_t S_SQ2   = PC_W'(10);
  localparam pc_t S_WAIT2 = PC_W'(13);
  localparam pc_t S_SEMI  = PC_W'(16);
  localparam pc_t S_EMIT  = PC_W'(17);
  localparam pc_t S_LAST  = PC_W'(PROG_LEN - 1);

  localparam value_t TWO      = VALUE_WIDTH'(2);
  localparam value_t SMALLEST = VALUE_WIDTH'(4);

  function automatic srt_cw_t mk_cw(input srt_op_t op, input srt_cond_t cond,
                                    input pc_t target);
    srt_cw_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control program: the first search finds the least divisor of the
  // candidate, the second checks that the cofactor has none.
  function automatic srt_cw_t ucode(input pc_t pc);
    srt_cw_t w;
    unique case (pc)
      PC_W'(0):  w = mk_cw(OP_IDLE,      C_NO_INPUT, S_IDLE);
      PC_W'(1):  w = mk_cw(OP_NONE,      C_SMALL,    S_EMIT);
      PC_W'(2):  w = mk_cw(OP_D_INIT,    C_NEXT,     S_IDLE);
      PC_W'(3):  w = mk_cw(OP_SQUARE,    C_NEXT,     S_IDLE);
      PC_W'(4):  w = mk_cw(OP_NONE,      C_SQ_GT,    S_EMIT);
      PC_W'(5):  w = mk_cw(OP_DIV_START, C_NEXT,     S_IDLE);
      PC_W'(6):  w = mk_cw(OP_NONE,      C_DIV_BUSY, S_WAIT1);
      PC_W'(7):  w = mk_cw(OP_NONE,      C_REM_ZERO, S_FOUND);
      PC_W'(8):  w = mk_cw(OP_D_INC,     C_ALWAYS,   S_SQ1);
      PC_W'(9):  w = mk_cw(OP_FOUND,     C_NEXT,     S_IDLE);
      PC_W'(10): w = mk_cw(OP_SQUARE,    C_NEXT,     S_IDLE);
      PC_W'(11): w = mk_cw(OP_NONE,      C_SQ_GT,    S_SEMI);
      PC_W'(12): w = mk_cw(OP_DIV_START, C_NEXT,     S_IDLE);
      PC_W'(13): w = mk_cw(OP_NONE,      C_DIV_BUSY, S_WAIT2);
      PC_W'(14): w = mk_cw(OP_NONE,      C_REM_ZERO, S_EMIT);
      PC_W'(15): w = mk_cw(OP_D_INC,     C_ALWAYS,   S_SQ2);
      PC_W'(16): w = mk_cw(OP_SEMI,      C_NEXT,     S_IDLE);
      PC_W'(17): w = mk_cw(OP_EMIT,      C_OUT_FULL, S_EMIT);
      default:   w = mk_cw(OP_NONE,      C_ALWAYS,   S_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/srt_in_if.sv =====
// ----------------------------------------------------------------------------
// srt_in_if
// Candidate channel: one item per candidate with its end-of-range mark.
// ----------------------------------------------------------------------------
interface srt_in_if import srt_pkg::*;;
  logic   valid;
  logic   ready;
  field_t candidate;
  logic   last_of_range;

  modport source (output valid, output candidate, output last_of_range, input ready);
  modport sink   (input valid, input candidate, input last_of_range, output ready);
endinterface

// ===== hdl/srt_out_if.sv =====
// ----------------------------------------------------------------------------
// srt_out_if
// Result channel: semiprime flag, both factors and the range summary.
// ----------------------------------------------------------------------------
interface srt_out_if import srt_pkg::*;;
  logic   valid;
  logic   ready;
  logic   is_semiprime;
  field_t small_factor;
  field_t cofactor;
  logic   range_done;
  logic   any_in_range;

  modport source (output valid, output is_semiprime, output small_factor,
                  output cofactor, output range_done, output any_in_range,
                  input ready);
  modport sink   (input valid, input is_semiprime, input small_factor,
                  input cofactor, input range_done, input any_in_range,
                  output ready);
endinterface

// ===== hdl/srt_divider.sv =====
// ----------------------------------------------------------------------------
// srt_divider
// Restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srt_divider import srt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  value_t dividend,
  input  value_t divisor,
  output logic   busy,
  output value_t quotient,
  output value_t remainder
);

  logic                   busy_r, busy_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  value_t                 quo_r, quo_nxt;
  value_t                 rem_r, rem_nxt;
  value_t                 dvs_r, dvs_nxt;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff     = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
      rem_nxt = diff[VALUE_WIDTH] ? shifted[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/srt_ctrl.sv =====
// ----------------------------------------------------------------------------
// srt_ctrl
// Step counter and program table; evaluates the jump condition of each step.
// ----------------------------------------------------------------------------
module srt_ctrl import srt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  srt_flags_t flags,
  output srt_cw_t    cw
);

  pc_t  pc_r, pc_nxt;
  logic take;

  assign cw = ucode(pc_r);

  always_comb begin
    unique case (cw.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = ~flags.in_fire;
      C_SMALL:    take = flags.tiny;
      C_SQ_GT:    take = flags.sq_gt;
      C_DIV_BUSY: take = flags.div_busy;
      C_REM_ZERO: take = flags.rem_zero;
      C_OUT_FULL: take = flags.out_full;
      default:    take = 1'b0;
    endcase
    if (take) begin
      pc_nxt = cw.target;
    end else if (pc_r == S_LAST) begin
      pc_nxt = S_IDLE;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hdl/semiprime_range_test.sv =====
// Candidates below four skip the trial division; for any other candidate each
// trial divisor of the two searches runs a division on the restoring divider.
// The block takes no new item until the last one is emitted; a new item is
// taken while a result waits. Reset: synchronous, active low; clears the step
// counter, output valid and the range's semiprime-seen bit.
// ----------------------------------------------------------------------------
// semiprime_range_test
// Microcoded trial-division semiprime tester with a per-range summary bit.
// ----------------------------------------------------------------------------
module semiprime_range_test import srt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  srt_in_if.sink        in_ch,
  srt_out_if.source     out_ch
);

  srt_cw_t    cw;
  srt_flags_t flags;
  logic       in_fire;
  logic       div_start, div_busy;
  value_t     quotient, remainder;

  value_t  num_r, num_nxt;
  value_t  div_r, div_nxt;
  value_t  p_r, p_nxt;
  square_t sq_r, sq_nxt;
  logic    last_r, last_nxt;
  logic    semi_r, semi_nxt;
  logic    seen_r, seen_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    o_semi_r, o_semi_nxt;
  field_t  o_small_r, o_small_nxt;
  field_t  o_cof_r, o_cof_nxt;
  logic    o_done_r, o_done_nxt;
  logic    o_any_r, o_any_nxt;
  logic    seen_all;

  assign in_ch.ready = (cw.op == OP_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign div_start   = (cw.op == OP_DIV_START);

  assign flags.in_fire  = in_fire;
  assign flags.tiny     = (num_r < SMALLEST);
  assign flags.sq_gt    = (sq_r > SQ_W'(num_r));
  assign flags.div_busy = div_busy;
  assign flags.rem_zero = (remainder == '0);
  assign flags.out_full = out_valid_r & ~out_ch.ready;

  srt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw)
  );

  srt_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (num_r),
    .divisor   (div_r),
    .busy      (div_busy),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign seen_all = seen_r | semi_r;

  always_comb begin
    num_nxt       = num_r;
    div_nxt       = div_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    last_nxt      = last_r;
    semi_nxt      = semi_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    o_semi_nxt    = o_semi_r;
    o_small_nxt   = o_small_r;
    o_cof_nxt     = o_cof_r;
    o_done_nxt    = o_done_r;
    o_any_nxt     = o_any_r;
    unique case (cw.op)
      OP_IDLE: begin
        if (in_fire) begin
          num_nxt  = VALUE_WIDTH'(in_ch.candidate);
          last_nxt = in_ch.last_of_range;
          semi_nxt = 1'b0;
        end
      end
      OP_D_INIT:    div_nxt = TWO;
      OP_SQUARE:    sq_nxt  = SQ_W'(div_r) * SQ_W'(div_r);
      OP_D_INC:     div_nxt = div_r + VALUE_WIDTH'(1);
      OP_FOUND: begin
        p_nxt   = div_r;
        num_nxt = quotient;
        div_nxt = TWO;
      end
      OP_SEMI:      semi_nxt = 1'b1;
      OP_EMIT: begin
        if (!flags.out_full) begin
          out_valid_nxt = 1'b1;
          o_semi_nxt    = semi_r;
          o_small_nxt   = semi_r ? FIELD_W'(p_r) : '0;
          o_cof_nxt     = semi_r ? FIELD_W'(num_r) : '0;
          o_done_nxt    = last_r;
          o_any_nxt     = last_r & seen_all;
          seen_nxt      = last_r ? 1'b0 : seen_all;
        end
      end
      OP_NONE, OP_DIV_START: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r     <= num_nxt;
    div_r     <= div_nxt;
    p_r       <= p_nxt;
    sq_r      <= sq_nxt;
    last_r    <= last_nxt;
    semi_r    <= semi_nxt;
    o_semi_r  <= o_semi_nxt;
    o_small_r <= o_small_nxt;
    o_cof_r   <= o_cof_nxt;
    o_done_r  <= o_done_nxt;
    o_any_r   <= o_any_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_semiprime = o_semi_r;
  assign out_ch.small_factor = o_small_r;
  assign out_ch.cofactor     = o_cof_r;
  assign out_ch.range_done   = o_done_r;
  assign out_ch.any_in_range = o_any_r;

endmodule

// ===== hdl/srt_checker.sv =====
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks on the result channel of the semiprime range tester.
// ----------------------------------------------------------------------------
`include "semiprime_range_test_defines.svh"

module srt_checker import srt_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   out_valid,
  input logic   out_ready,
  input logic   out_is_semiprime,
  input field_t out_small_factor,
  input field_t out_cofactor,
  input logic   out_range_done,
  input logic   out_any_in_range
);

  `SRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SRT_ASSERT_SAME(a_zero_factors, out_valid && !out_is_semiprime, (out_small_factor == '0) && (out_cofactor == '0))
  `SRT_ASSERT_SAME(a_factor_order, out_valid && out_is_semiprime, (out_small_factor >= FIELD_W'(2)) && (out_cofactor >= out_small_factor))
  `SRT_ASSERT_SAME(a_any_only_done, out_valid && !out_range_done, !out_any_in_range)
  `SRT_ASSERT_SAME(a_any_counts_self, out_valid && out_range_done && out_is_semiprime, out_any_in_range)

endmodule

bind semiprime_range_test srt_checker u_srt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_is_semiprime (out_ch.is_semiprime),
  .out_small_factor (out_ch.small_factor),
  .out_cofactor     (out_ch.cofactor),
  .out_range_done   (out_ch.range_done),
  .out_any_in_range (out_ch.any_in_range)
);

// ===== tb/semiprime_range_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semiprime_range_test_tb
// Drives candidate items into the semiprime range tester and checks every
// result item against a trial-division predictor kept in step with the
// block's range-summary bit. Directed cases cover tiny, prime, square and
// boundary candidates and the range summary. Random ranges follow, with idle
// bursts on both sides, a long output hold-off and a quiet final stretch.
// ----------------------------------------------------------------------------
module semiprime_range_test_tb;
  import srt_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 30;

  typedef struct packed {
    logic   is_semiprime;
    field_t small_factor;
    field_t cofactor;
    logic   range_done;
    logic   any_in_range;
  } semiprime_verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  semiprime_range_test dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  semiprime_verdict_t verdict_q[$];
  logic range_seen  = 1'b0;
  bit   quiet       = 1'b0;
  bit   sender_gaps = 1'b1;
  bit   hold_req    = 1'b0;
  int   errors      = 0;
  int   results_seen = 0;
  int   semis_seen  = 0;
  int   ranges_seen = 0;
  int   idle_cycles = 0;

  function automatic longint unsigned least_divisor(input longint unsigned n);
    longint unsigned d;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return d;
    end
    return 0;
  endfunction

  function automatic semiprime_verdict_t predict_verdict(input field_t cand,
                                                         input logic last);
    longint unsigned n;
    longint unsigned d;
    longint unsigned m;
    semiprime_verdict_t v;
    n = longint'(value_t'(cand));
    v = '0;
    if (n >= 4) begin
      d = least_divisor(n);
      if (d != 0) begin
        m = n / d;
        if (m >= 2 && least_divisor(m) == 0) begin
          v.is_semiprime = 1'b1;
          v.small_factor = field_t'(d);
          v.cofactor     = field_t'(m);
        end
      end
    end
    if (v.is_semiprime) range_seen = 1'b1;
    v.range_done   = last;
    v.any_in_range = last ? range_seen : 1'b0;
    if (last) range_seen = 1'b0;
    return v;
  endfunction

  function automatic field_t random_candidate();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return field_t'($urandom_range(0, 255));
    if (pick < 9) return field_t'($urandom_range(256, 4095));
    return field_t'($urandom_range(4096, 65535));
  endfunction

  task automatic send_item(input field_t cand, input logic last);
    int gap;
    if (!quiet && sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.candidate     <= cand;
    in_ch.last_of_range <= last;
    do @(posedge clk); while (!in_ch.ready);
    verdict_q.push_back(predict_verdict(cand, last));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_small_values();
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd3, 1'b1);
    send_item(16'd4, 1'b1);
  endtask

  task automatic test_factor_shapes();
    send_item(16'd6, 1'b0);
    send_item(16'd8, 1'b0);
    send_item(16'd9, 1'b0);
    send_item(16'd12, 1'b0);
    send_item(16'd30, 1'b0);
    send_item(16'd49, 1'b0);
    send_item(16'd97, 1'b1);
  endtask

  task automatic test_extremes();
    send_item(16'd32768, 1'b0);
    send_item(16'd63001, 1'b0);
    send_item(16'd64507, 1'b0);
    send_item(16'd65521, 1'b0);
    send_item(16'd65534, 1'b0);
    send_item(16'd65535, 1'b1);
  endtask

  task automatic test_missing_end();
    send_item(16'd10, 1'b0);
    send_item(16'd16, 1'b0);
    send_item(16'd17, 1'b1);
    send_item(16'd16, 1'b0);
    send_item(16'd17, 1'b1);
  endtask

  // The receiver stalls long enough for the block to hold a result and a
  // second item, so the input channel has to stall as well.
  task automatic test_backpressure();
    wait_drained();
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    for (int i = 1; i <= 8; i++) send_item(field_t'(i), i == 8);
    sender_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_ranges(input int count);
    int sent;
    int len;
    field_t cand;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(random_candidate(), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len  = $urandom_range(1, 12);
        cand = random_candidate();
        for (int i = 0; i < len; i++) begin
          send_item(cand, i == len - 1);
          if (cand <= 16'hFFFC) cand = cand + field_t'($urandom_range(1, 3));
        end
        sent += len;
      end
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    semiprime_verdict_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.is_semiprime) semis_seen++;
      if (out_ch.range_done) ranges_seen++;
      if (verdict_q.size() == 0) begin
        $error("result item arrived with no expected result pending");
        errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_ch.is_semiprime !== exp_v.is_semiprime) begin
          $error("is_semiprime: expected %0d, actual %0d",
                 exp_v.is_semiprime, out_ch.is_semiprime);
          errors++;
        end
        if (out_ch.small_factor !== exp_v.small_factor) begin
          $error("small_factor: expected %0d, actual %0d",
                 exp_v.small_factor, out_ch.small_factor);
          errors++;
        end
        if (out_ch.cofactor !== exp_v.cofactor) begin
          $error("cofactor: expected %0d, actual %0d",
                 exp_v.cofactor, out_ch.cofactor);
          errors++;
        end
        if (out_ch.range_done !== exp_v.range_done) begin
          $error("range_done: expected %0d, actual %0d",
                 exp_v.range_done, out_ch.range_done);
          errors++;
        end
        if (out_ch.any_in_range !== exp_v.any_in_range) begin
          $error("any_in_range: expected %0d, actual %0d",
                 exp_v.any_in_range, out_ch.any_in_range);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.candidate     = '0;
    in_ch.last_of_range = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_small_values();
    test_factor_shapes();
    test_extremes();
    test_missing_end();
    test_backpressure();
    test_random_ranges(540);
    wait_drained();
    quiet = 1'b1;
    test_random_ranges(60);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d result items over %0d ranges, %0d of them semiprime,",
             results_seen, ranges_seen, semis_seen);
    $display("with idle bursts on both sides, a long output stall and a quiet tail.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
